### src/dssm_pkg.sv
`timescale 1ns / 1ps
// Package for the dual stack block: command and status codes and the
// transaction types of the command and result channels. No dependencies.
package dssm_pkg;

    localparam logic [2:0] CMD_PUSH_A = 3'd0;
    localparam logic [2:0] CMD_POP_A  = 3'd1;
    localparam logic [2:0] CMD_PUSH_B = 3'd2;
    localparam logic [2:0] CMD_POP_B  = 3'd3;
    localparam logic [2:0] CMD_DUMP_A = 3'd4;
    localparam logic [2:0] CMD_DUMP_B = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] push_value;
    } t_cmd_item;

    typedef struct packed {
        logic signed [31:0] data_out;
        logic [1:0]         status;
        logic               last;
    } t_result_item;

endpackage

### src/dssm_mem.sv
`timescale 1ns / 1ps
// Single-port word memory shared by both stacks, with a registered read.
// Depends on nothing but its DEPTH parameter.
module dssm_mem #(
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [31:0]              i_wdata,
    output logic [31:0]              o_rdata
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/dual_stack_shared_memory.sv
`timescale 1ns / 1ps
// Top level of the dual stack block: command sequencer, stack counters and
// the shared pointer unit. Depends on dssm_pkg and dssm_mem.
//
// Two LIFO stacks live in one memory of DEPTH words: stack A grows up from
// word 0 and stack B grows down from word DEPTH-1. A command transaction is
// taken at a rising edge where start is high and busy is low. Results appear
// on o_result for exactly one cycle, marked by o_valid; the receiver cannot
// stall them, so it must take each one as it comes.
// A push or a pop gives a single result, valid in the cycle after the
// command, and a new command may follow in every cycle. A dump
// walks the stack with one memory read per cycle, so a dump of n entries
// gives n results in consecutive cycles and holds busy high while it issues
// every read after the first; a dump of an empty stack gives one result.
// Unused command codes are taken and give no result.
// The synchronous reset empties both stacks; memory contents are left as
// they are and are never read before written.
module dual_stack_shared_memory
    import dssm_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         start,
    output logic         busy,
    input  t_cmd_item    i_item,
    output logic         o_valid,
    output t_result_item o_result
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DUMP = 2'b10
    } t_state;

    t_state         r_state, n_state;
    logic [CW-1:0]  r_cnt_a, n_cnt_a;
    logic [CW-1:0]  r_cnt_b, n_cnt_b;
    logic [AW-1:0]  r_ptr, n_ptr;
    logic [CW-1:0]  r_left, n_left;
    logic           r_up, n_up;
    logic           r_valid, n_valid;
    logic [31:0]    r_data, n_data;
    logic [1:0]     r_status, n_status;
    logic           r_last, n_last;
    logic           r_from_mem, n_from_mem;

    logic           mem_we;
    logic           mem_re;
    logic [AW-1:0]  mem_addr;
    logic [31:0]    mem_rdata;

    logic [CW:0]    w_sum;
    logic           w_full;
    logic [CW-1:0]  w_top_a;
    logic [CW-1:0]  w_top_b;
    logic [CW-1:0]  w_free_b;

    dssm_mem #(
        .DEPTH(DEPTH)
    ) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_re   (mem_re),
        .i_addr (mem_addr),
        .i_wdata(i_item.push_value),
        .o_rdata(mem_rdata)
    );

    assign busy     = (r_state == S_DUMP);
    assign w_sum    = {1'b0, r_cnt_a} + {1'b0, r_cnt_b};
    assign w_full   = (w_sum >= (CW+1)'(DEPTH));
    assign w_top_a  = r_cnt_a - CW'(1);
    assign w_top_b  = CW'(DEPTH) - r_cnt_b;
    assign w_free_b = w_top_b - CW'(1);

    always_comb begin
        n_state    = r_state;
        n_cnt_a    = r_cnt_a;
        n_cnt_b    = r_cnt_b;
        n_ptr      = r_ptr;
        n_left     = r_left;
        n_up       = r_up;
        n_valid    = 1'b0;
        n_data     = '0;
        n_status   = ST_OK;
        n_last     = 1'b1;
        n_from_mem = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_addr   = r_ptr;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_item.command)
                        CMD_PUSH_A: begin
                            n_valid = 1'b1;
                            if (w_full) begin
                                n_status = ST_OVERFLOW;
                            end else begin
                                mem_we   = 1'b1;
                                mem_addr = r_cnt_a[AW-1:0];
                                n_cnt_a  = r_cnt_a + CW'(1);
                            end
                        end
                        CMD_PUSH_B: begin
                            n_valid = 1'b1;
                            if (w_full) begin
                                n_status = ST_OVERFLOW;
                            end else begin
                                mem_we   = 1'b1;
                                mem_addr = w_free_b[AW-1:0];
                                n_cnt_b  = r_cnt_b + CW'(1);
                            end
                        end
                        CMD_POP_A: begin
                            n_valid = 1'b1;
                            if (r_cnt_a == '0) begin
                                n_data   = '1;
                                n_status = ST_UNDERFLOW;
                            end else begin
                                mem_re     = 1'b1;
                                mem_addr   = w_top_a[AW-1:0];
                                n_from_mem = 1'b1;
                                n_cnt_a    = w_top_a;
                            end
                        end
                        CMD_POP_B: begin
                            n_valid = 1'b1;
                            if (r_cnt_b == '0) begin
                                n_data   = '1;
                                n_status = ST_UNDERFLOW;
                            end else begin
                                mem_re     = 1'b1;
                                mem_addr   = w_top_b[AW-1:0];
                                n_from_mem = 1'b1;
                                n_cnt_b    = r_cnt_b - CW'(1);
                            end
                        end
                        CMD_DUMP_A: begin
                            n_valid = 1'b1;
                            if (r_cnt_a == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                mem_re     = 1'b1;
                                mem_addr   = w_top_a[AW-1:0];
                                n_from_mem = 1'b1;
                                n_last     = (r_cnt_a == CW'(1));
                                n_ptr      = w_top_a[AW-1:0] - AW'(1);
                                n_left     = w_top_a;
                                n_up       = 1'b0;
                                if (r_cnt_a != CW'(1)) begin
                                    n_state = S_DUMP;
                                end
                            end
                        end
                        CMD_DUMP_B: begin
                            n_valid = 1'b1;
                            if (r_cnt_b == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                mem_re     = 1'b1;
                                mem_addr   = w_top_b[AW-1:0];
                                n_from_mem = 1'b1;
                                n_last     = (r_cnt_b == CW'(1));
                                n_ptr      = w_top_b[AW-1:0] + AW'(1);
                                n_left     = r_cnt_b - CW'(1);
                                n_up       = 1'b1;
                                if (r_cnt_b != CW'(1)) begin
                                    n_state = S_DUMP;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DUMP: begin
                n_valid    = 1'b1;
                mem_re     = 1'b1;
                mem_addr   = r_ptr;
                n_from_mem = 1'b1;
                n_last     = (r_left == CW'(1));
                n_ptr      = r_up ? (r_ptr + AW'(1)) : (r_ptr - AW'(1));
                n_left     = r_left - CW'(1);
                if (r_left == CW'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt_a    <= '0;
            r_cnt_b    <= '0;
            r_valid    <= 1'b0;
            r_from_mem <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt_a    <= n_cnt_a;
            r_cnt_b    <= n_cnt_b;
            r_valid    <= n_valid;
            r_from_mem <= n_from_mem;
        end
        r_ptr    <= n_ptr;
        r_left   <= n_left;
        r_up     <= n_up;
        r_data   <= n_data;
        r_status <= n_status;
        r_last   <= n_last;
    end

    assign o_valid           = r_valid;
    assign o_result.data_out = r_from_mem ? mem_rdata : r_data;
    assign o_result.status   = r_status;
    assign o_result.last     = r_last;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sum <= (CW+1)'(DEPTH))
        else $error("Stack counters exceed the memory depth.");

    a_dump_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP) |=> o_valid)
        else $error("Dump cycle gave no result.");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.last) |-> (r_state == S_DUMP))
        else $error("Result run ended without a final result.");

    a_cmd_answered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_item.command <= CMD_DUMP_B)) |=> o_valid)
        else $error("Valid command gave no result.");

endmodule

### sim/dual_stack_shared_memory_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for dual_stack_shared_memory: a directed table, then
// random push, pop and dump traffic checked against an in-bench stack predictor.
// Depends on dssm_pkg and the RTL of the block.
module dual_stack_shared_memory_tb;
    import dssm_pkg::*;

    localparam int DEPTH = 64;
    localparam int RANDOM_ITEMS = 128;
    localparam int QUIET_TAIL = 30;
    localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
    localparam logic [2:0] CMD_UNUSED_7 = 3'd7;

    typedef struct packed {
        t_cmd_item    cmd;
        logic         typed;
        t_result_item want;
    } t_directed_row;

    localparam t_directed_row DIRECTED_ROWS [22] = '{
        '{'{CMD_POP_A,    32'sd0},            1'b1, '{-32'sd1, ST_UNDERFLOW, 1'b1}},
        '{'{CMD_POP_B,    32'sd0},            1'b1, '{-32'sd1, ST_UNDERFLOW, 1'b1}},
        '{'{CMD_DUMP_A,   32'sd0},            1'b1, '{32'sd0, ST_EMPTY, 1'b1}},
        '{'{CMD_DUMP_B,   32'sd0},            1'b1, '{32'sd0, ST_EMPTY, 1'b1}},
        '{'{CMD_PUSH_A,   32'sh7FFF_FFFF},    1'b1, '{32'sd0, ST_OK, 1'b1}},
        '{'{CMD_PUSH_A,   32'sh8000_0000},    1'b1, '{32'sd0, ST_OK, 1'b1}},
        '{'{CMD_PUSH_A,   32'sd0},            1'b1, '{32'sd0, ST_OK, 1'b1}},
        '{'{CMD_PUSH_B,   32'shFFFF_FFFF},    1'b1, '{32'sd0, ST_OK, 1'b1}},
        '{'{CMD_PUSH_B,   32'sd1},            1'b1, '{32'sd0, ST_OK, 1'b1}},
        '{'{CMD_UNUSED_6, 32'sh5555_5555},    1'b0, '0},
        '{'{CMD_UNUSED_7, 32'shAAAA_AAAA},    1'b0, '0},
        '{'{CMD_DUMP_A,   32'sd0},            1'b0, '0},
        '{'{CMD_DUMP_B,   32'sd0},            1'b0, '0},
        '{'{CMD_POP_A,    32'sd0},            1'b0, '0},
        '{'{CMD_POP_B,    32'sd0},            1'b0, '0},
        '{'{CMD_POP_B,    32'sh7FFF_FFFF},    1'b0, '0},
        '{'{CMD_POP_B,    32'sd0},            1'b1, '{-32'sd1, ST_UNDERFLOW, 1'b1}},
        '{'{CMD_DUMP_A,   32'sd0},            1'b0, '0},
        '{'{CMD_POP_A,    32'sd0},            1'b0, '0},
        '{'{CMD_POP_A,    32'sd0},            1'b0, '0},
        '{'{CMD_POP_A,    32'shFFFF_FFFF},    1'b1, '{-32'sd1, ST_UNDERFLOW, 1'b1}},
        '{'{CMD_DUMP_B,   32'sd0},            1'b1, '{32'sd0, ST_EMPTY, 1'b1}}
    };

    logic         i_clk;
    logic         i_rst_n;
    logic         start;
    logic         busy;
    t_cmd_item    i_item;
    logic         o_valid;
    t_result_item o_result;

    logic signed [31:0] shadow_words [DEPTH];
    int                 fill_a;
    int                 fill_b;
    t_result_item       step_results [$];
    t_result_item       pending_results [$];

    int  n_errors;
    int  n_results;
    int  n_commands;
    int  n_ignored;
    int  n_random;
    int  n_overflows;
    int  n_full_dumps;
    bit  quiet;

    dual_stack_shared_memory #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic t_result_item make_result(logic signed [31:0] data, logic [1:0] st,
                                                 logic lst);
        t_result_item r;
        r.data_out = data;
        r.status   = st;
        r.last     = lst;
        return r;
    endfunction

    // Updates the shadow stacks for one command and leaves its results in step_results.
    function automatic void stack_step(t_cmd_item c);
        int idx;
        step_results = {};
        case (c.command)
            CMD_PUSH_A, CMD_PUSH_B: begin
                if (fill_a + fill_b >= DEPTH) begin
                    step_results.push_back(make_result(32'sd0, ST_OVERFLOW, 1'b1));
                end else begin
                    if (c.command == CMD_PUSH_A) begin
                        shadow_words[fill_a] = c.push_value;
                        fill_a++;
                    end else begin
                        shadow_words[DEPTH - 1 - fill_b] = c.push_value;
                        fill_b++;
                    end
                    step_results.push_back(make_result(32'sd0, ST_OK, 1'b1));
                end
            end
            CMD_POP_A: begin
                if (fill_a == 0) begin
                    step_results.push_back(make_result(-32'sd1, ST_UNDERFLOW, 1'b1));
                end else begin
                    fill_a--;
                    step_results.push_back(make_result(shadow_words[fill_a], ST_OK, 1'b1));
                end
            end
            CMD_POP_B: begin
                if (fill_b == 0) begin
                    step_results.push_back(make_result(-32'sd1, ST_UNDERFLOW, 1'b1));
                end else begin
                    step_results.push_back(
                        make_result(shadow_words[DEPTH - fill_b], ST_OK, 1'b1));
                    fill_b--;
                end
            end
            CMD_DUMP_A: begin
                if (fill_a == 0) begin
                    step_results.push_back(make_result(32'sd0, ST_EMPTY, 1'b1));
                end else begin
                    for (idx = fill_a - 1; idx >= 0; idx--) begin
                        step_results.push_back(make_result(shadow_words[idx], ST_OK, idx == 0));
                    end
                end
            end
            CMD_DUMP_B: begin
                if (fill_b == 0) begin
                    step_results.push_back(make_result(32'sd0, ST_EMPTY, 1'b1));
                end else begin
                    for (idx = DEPTH - fill_b; idx < DEPTH; idx++) begin
                        step_results.push_back(
                            make_result(shadow_words[idx], ST_OK, idx == DEPTH - 1));
                    end
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic logic signed [31:0] random_word();
        case ($urandom_range(0, 11))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return -32'sd1;
            3:       return 32'sd0;
            default: return $urandom();
        endcase
    endfunction

    // Push-heavy while building the stacks up, pop-heavy while draining them.
    function automatic logic [2:0] random_command(bit draining);
        int roll;
        int push_cut;
        roll = $urandom_range(0, 99);
        push_cut = draining ? 30 : 55;
        if (roll < push_cut) begin
            return $urandom_range(0, 1) ? CMD_PUSH_A : CMD_PUSH_B;
        end else if (roll < 82) begin
            return $urandom_range(0, 1) ? CMD_POP_A : CMD_POP_B;
        end else if (roll < 94) begin
            return $urandom_range(0, 1) ? CMD_DUMP_A : CMD_DUMP_B;
        end
        return $urandom_range(0, 1) ? CMD_UNUSED_6 : CMD_UNUSED_7;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_command(t_cmd_item c, logic typed, t_result_item want);
        start  = 1'b1;
        i_item = c;
        do begin
            @(posedge i_clk);
        end while (busy);
        @(negedge i_clk);
        stack_step(c);
        if (c.command == CMD_DUMP_A && fill_a == DEPTH) n_full_dumps++;
        if (c.command == CMD_DUMP_B && fill_b == DEPTH) n_full_dumps++;
        if (step_results.size() == 1 && step_results[0].status == ST_OVERFLOW) n_overflows++;
        if (typed) begin
            pending_results.push_back(want);
        end else begin
            foreach (step_results[k]) pending_results.push_back(step_results[k]);
        end
        n_commands++;
        if (step_results.size() == 0) n_ignored++;
    endtask

    task automatic maybe_idle();
        if (!quiet && $urandom_range(0, 3) == 0) begin
            start = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        start = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic send_random(logic [2:0] cmd);
        t_cmd_item c;
        c.command    = cmd;
        c.push_value = random_word();
        send_command(c, 1'b0, '0);
        if (cmd != CMD_UNUSED_6 && cmd != CMD_UNUSED_7) n_random++;
        quiet = (n_random >= RANDOM_ITEMS - QUIET_TAIL);
        maybe_idle();
    endtask

    always @(posedge i_clk) begin : result_checker
        t_result_item want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $error("Result with no transaction pending: data_out %0d status %0d last %0d",
                       o_result.data_out, o_result.status, o_result.last);
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                n_results++;
                if (o_result.data_out !== want.data_out) begin
                    $error("data_out mismatch: expected %0d, actual %0d",
                           want.data_out, o_result.data_out);
                    n_errors++;
                end
                if (o_result.status !== want.status) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           want.status, o_result.status);
                    n_errors++;
                end
                if (o_result.last !== want.last) begin
                    $error("last mismatch: expected %0d, actual %0d",
                           want.last, o_result.last);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : stimulus
        int guard;
        n_errors     = 0;
        n_results    = 0;
        n_commands   = 0;
        n_ignored    = 0;
        n_random     = 0;
        n_overflows  = 0;
        n_full_dumps = 0;
        quiet        = 1'b0;
        fill_a       = 0;
        fill_b       = 0;
        foreach (shadow_words[k]) shadow_words[k] = '0;
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_item  = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (DIRECTED_ROWS[r]) begin
            send_command(DIRECTED_ROWS[r].cmd, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
            maybe_idle();
        end
        wait_drained();

        // One stack alone at full depth, dumped from its top to its base.
        while (fill_a < DEPTH) send_random(CMD_PUSH_A);
        send_random(CMD_PUSH_B);
        send_random(CMD_DUMP_A);
        send_random(CMD_DUMP_B);
        wait_drained();

        // Make room for stack B, fill it until the stacks meet, then push into the full memory.
        while (fill_a > DEPTH - DEPTH / 4) send_random(CMD_POP_A);
        while (fill_a + fill_b < DEPTH) send_random(CMD_PUSH_B);
        repeat (3) send_random($urandom_range(0, 1) ? CMD_PUSH_A : CMD_PUSH_B);
        send_random(CMD_DUMP_A);
        send_random(CMD_DUMP_B);
        send_random($urandom_range(0, 1) ? CMD_POP_A : CMD_POP_B);
        send_random($urandom_range(0, 1) ? CMD_PUSH_B : CMD_PUSH_A);

        while (n_random < RANDOM_ITEMS) send_random(random_command(1'b1));
        start = 1'b0;

        guard = 0;
        while (pending_results.size() != 0 && guard < 5000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (DEPTH + 4) @(negedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            n_errors++;
        end

        $display("Run covered %0d command transactions (%0d with unused codes), %0d results",
                 n_commands, n_ignored, n_results);
        $display("checked, including %0d overflowed pushes and %0d dumps of a full stack.",
                 n_overflows, n_full_dumps);
        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### dual_stack_shared_memory.f
src/dssm_pkg.sv
src/dssm_mem.sv
src/dual_stack_shared_memory.sv
sim/dual_stack_shared_memory_tb.sv
